FILE: hw/rtl/ldf_pkg.sv
// Shared types and constants for the lidar packet deframer.
package ldf_pkg;

    // Frame sync pair
    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    // Section lengths in bytes
    localparam int HEADER_BYTES = 6;
    localparam int FOOTER_BYTES = 4;
    localparam int WORD_BYTES   = 4;

    // Header byte positions
    localparam logic [2:0] HDR_LEAD     = 3'd0;
    localparam logic [2:0] HDR_COUNT    = 3'd1;
    localparam logic [2:0] HDR_SPEED_LO = 3'd2;
    localparam logic [2:0] HDR_SPEED_HI = 3'd3;
    localparam logic [2:0] HDR_ANGLE_LO = 3'd4;

    // Byte lanes of a little-endian word
    localparam logic [1:0] LANE_0 = 2'd0;
    localparam logic [1:0] LANE_1 = 2'd1;
    localparam logic [1:0] LANE_2 = 2'd2;
    localparam logic [1:0] LANE_3 = 2'd3;

    // Result field widths and stream packing
    localparam int INDEX_W  = 4;
    localparam int WORD_W   = 32;
    localparam int LEAD_W   = 8;
    localparam int SPEED_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int CHECK_W  = 32;
    localparam int FIELDS_W = INDEX_W + WORD_W + LEAD_W + SPEED_W + ANGLE_W + CHECK_W;
    localparam int M_TDATA_W = ((FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - FIELDS_W;

    // Controller states
    typedef enum logic [2:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_HEADER,
        ST_PAYLOAD,
        ST_FOOTER,
        ST_EMIT
    } ldf_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic cnt_clear;
        logic cnt_inc;
        logic take_header;
        logic take_payload;
        logic take_footer;
        logic idx_clear;
        logic idx_advance;
    } ldf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sync_first;
        logic sync_second;
        logic hdr_end;
        logic pay_end;
        logic ftr_end;
        logic count_ok;
        logic emit_last;
    } ldf_status_t;

endpackage

FILE: hw/rtl/ldf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ldf_ram
    import ldf_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/ldf_ctrl.sv
// Controller state machine: sync hunt, section sequencing and result burst.
module ldf_ctrl
    import ldf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  ldf_status_t status,
    output ldf_cmd_t    cmd
);

    ldf_state_t state_reg;
    ldf_state_t state_next;
    logic       in_accept;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT1;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold input off while the result burst is out
    assign s_tready  = (state_reg != ST_EMIT);
    assign in_accept = s_tvalid && s_tready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_HUNT1: begin
                if (in_accept) begin
                    state_next = status.sync_first ? ST_HUNT2 : ST_HUNT1;
                end
            end
            ST_HUNT2: begin
                if (in_accept) begin
                    if (status.sync_second) begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = ST_HEADER;
                    end else begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            ST_HEADER: begin
                if (in_accept) begin
                    cmd.take_header = 1'b1;
                    if (status.hdr_end) begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = status.count_ok ? ST_PAYLOAD : ST_HUNT1;
                    end else begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (in_accept) begin
                    cmd.take_payload = 1'b1;
                    if (status.pay_end) begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = ST_FOOTER;
                    end else begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_FOOTER: begin
                if (in_accept) begin
                    cmd.take_footer = 1'b1;
                    if (status.ftr_end) begin
                        cmd.cnt_clear = 1'b1;
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_EMIT;
                    end else begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (status.emit_last) begin
                        state_next = ST_HUNT1;
                    end else begin
                        cmd.idx_advance = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_HUNT1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ldf_datapath.sv
// Datapath: byte counter, header and checksum registers, point store and readout.
module ldf_datapath
    import ldf_pkg::*;
#(
    parameter int POINTS_PER_PACKET = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          rx_byte,
    input  ldf_cmd_t            cmd,
    output ldf_status_t         status,
    output logic [INDEX_W-1:0]  point_index,
    output logic [WORD_W-1:0]   point_word,
    output logic [LEAD_W-1:0]   lead_byte,
    output logic [SPEED_W-1:0]  rotation_speed,
    output logic [ANGLE_W-1:0]  first_angle,
    output logic [CHECK_W-1:0]  packet_check
);

    localparam int PAYLOAD_BYTES = WORD_BYTES * POINTS_PER_PACKET;
    localparam int CNT_MAX = (PAYLOAD_BYTES > HEADER_BYTES) ? PAYLOAD_BYTES : HEADER_BYTES;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int ADDR_W  = (POINTS_PER_PACKET > 1) ? $clog2(POINTS_PER_PACKET) : 1;

    logic [CNT_W-1:0]   byte_count_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [INDEX_W-1:0] pidx_reg;
    logic [7:0]         held_count_reg;
    logic [LEAD_W-1:0]  held_lead_reg;
    logic [SPEED_W-1:0] held_speed_reg;
    logic [ANGLE_W-1:0] held_angle_reg;
    logic [23:0]        word_partial_reg;
    logic [23:0]        check_partial_reg;
    logic [CHECK_W-1:0] check_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;

    // Section byte counter and readout index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            idx_reg        <= '0;
            pidx_reg       <= '0;
        end else begin
            if (cmd.cnt_clear) begin
                byte_count_reg <= '0;
            end else if (cmd.cnt_inc) begin
                byte_count_reg <= byte_count_reg + 1'b1;
            end
            if (cmd.idx_clear) begin
                idx_reg  <= '0;
                pidx_reg <= '0;
            end else if (cmd.idx_advance) begin
                idx_reg  <= idx_reg + 1'b1;
                pidx_reg <= pidx_reg + 1'b1;
            end
        end
    end

    // Capture header, word and checksum bytes
    always_ff @(posedge aclk) begin
        if (cmd.take_header) begin
            unique case (byte_count_reg[2:0])
                HDR_LEAD:     held_lead_reg         <= rx_byte;
                HDR_COUNT:    held_count_reg        <= rx_byte;
                HDR_SPEED_LO: held_speed_reg[7:0]   <= rx_byte;
                HDR_SPEED_HI: held_speed_reg[15:8]  <= rx_byte;
                HDR_ANGLE_LO: held_angle_reg[7:0]   <= rx_byte;
                default:      held_angle_reg[15:8]  <= rx_byte;
            endcase
        end
        if (cmd.take_payload) begin
            case (byte_count_reg[1:0])
                LANE_0:  word_partial_reg[7:0]   <= rx_byte;
                LANE_1:  word_partial_reg[15:8]  <= rx_byte;
                LANE_2:  word_partial_reg[23:16] <= rx_byte;
                default: ;
            endcase
        end
        if (cmd.take_footer) begin
            case (byte_count_reg[1:0])
                LANE_0:  check_partial_reg[7:0]   <= rx_byte;
                LANE_1:  check_partial_reg[15:8]  <= rx_byte;
                LANE_2:  check_partial_reg[23:16] <= rx_byte;
                default: check_reg <= {rx_byte, check_partial_reg};
            endcase
        end
    end

    // Write a finished point word on its top byte
    assign wr_en = cmd.take_payload && (byte_count_reg[1:0] == LANE_3);

    // Read address leads the index so the next word is ready after a transaction
    always_comb begin
        if (cmd.idx_clear) begin
            rd_addr = '0;
        end else if (cmd.idx_advance) begin
            rd_addr = idx_reg + 1'b1;
        end else begin
            rd_addr = idx_reg;
        end
    end

    ldf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (POINTS_PER_PACKET)
    ) u_point_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (byte_count_reg[ADDR_W+1:2]),
        .wr_data ({rx_byte, word_partial_reg}),
        .rd_addr (rd_addr),
        .rd_data (point_word)
    );

    // Status to the controller
    assign status.sync_first  = (rx_byte == SYNC_FIRST);
    assign status.sync_second = (rx_byte == SYNC_SECOND);
    assign status.hdr_end     = (byte_count_reg == CNT_W'(HEADER_BYTES - 1));
    assign status.pay_end     = (byte_count_reg == CNT_W'(PAYLOAD_BYTES - 1));
    assign status.ftr_end     = (byte_count_reg == CNT_W'(FOOTER_BYTES - 1));
    assign status.count_ok    = (held_count_reg == 8'(POINTS_PER_PACKET));
    assign status.emit_last   = (idx_reg == ADDR_W'(POINTS_PER_PACKET - 1));

    assign point_index    = pidx_reg;
    assign lead_byte      = held_lead_reg;
    assign rotation_speed = held_speed_reg;
    assign first_angle    = held_angle_reg;
    assign packet_check   = check_reg;

endmodule

FILE: hw/rtl/lidar_packet_deframer.sv
// Lidar packet deframer top level: stream ports, controller and datapath.
//
// Usage: feed received serial bytes on the slave stream (s_tdata, one byte per
// transaction). The block hunts for the sync pair 0x55, 0xAA, takes a 6-byte
// header (lead byte, point count, speed LE, start angle LE), drops the packet
// if the count differs from POINTS_PER_PACKET, else stores 4*POINTS_PER_PACKET
// payload bytes as point words and a 4-byte checksum (not verified).
// The controller accepts one byte per cycle while framing.
// After the last checksum byte the master stream carries POINTS_PER_PACKET
// results, the first in the next cycle, then one per cycle while m_tready stays
// high; m_tlast marks the final point. The burst rate is set by the point
// store's registered read port, whose address runs one result ahead.
// During the burst s_tready is low; a stalled receiver holds the current
// result stable and holds the input off until the burst has drained.
// Reset (aresetn low, synchronous) returns the block to hunting the first
// sync byte with no result pending.
module lidar_packet_deframer
    import ldf_pkg::*;
#(
    parameter int POINTS_PER_PACKET = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [3:0] point_index, [35:4] point_word, [43:36] lead_byte,
    // [59:44] rotation_speed, [75:60] first_angle, [107:76] packet_check
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast    // last_point
);

    ldf_cmd_t           cmd;
    ldf_status_t        status;
    logic [INDEX_W-1:0] point_index;
    logic [WORD_W-1:0]  point_word;
    logic [LEAD_W-1:0]  lead_byte;
    logic [SPEED_W-1:0] rotation_speed;
    logic [ANGLE_W-1:0] first_angle;
    logic [CHECK_W-1:0] packet_check;

    ldf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ldf_datapath #(
        .POINTS_PER_PACKET (POINTS_PER_PACKET)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .rx_byte        (s_tdata),
        .cmd            (cmd),
        .status         (status),
        .point_index    (point_index),
        .point_word     (point_word),
        .lead_byte      (lead_byte),
        .rotation_speed (rotation_speed),
        .first_angle    (first_angle),
        .packet_check   (packet_check)
    );

    // Pack result fields, lowest field first
    assign m_tdata = {{M_PAD_W{1'b0}}, packet_check, first_angle, rotation_speed,
                      lead_byte, point_word, point_index};
    assign m_tlast = status.emit_last;

endmodule

FILE: hw/rtl/ldf_checker.sv
// Port-level assertions for the lidar packet deframer, bound to the top level.
module ldf_checker
    import ldf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [7:0]           s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic m_xfer;
    assign m_xfer = m_tvalid && m_tready;

    // No input transaction while a burst is out
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted during result burst");

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // Burst continues without gaps until the last point
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && !m_tlast) |=> (m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1)))
        else $error("burst gap or point index skipped");

    // After the last point the block returns to taking bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block did not return to hunting after last point");

    // A burst only starts on an input transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !(s_tvalid && s_tready)) |=> !m_tvalid)
        else $error("result appeared without an input transaction");

endmodule

bind lidar_packet_deframer ldf_checker u_ldf_checker (.*);

FILE: test/lidar_packet_deframer_checker.sv
// Point checker for the lidar packet deframer: tracks the byte stream and compares results.
`timescale 1ns / 1ps

module lidar_packet_deframer_checker
    import ldf_pkg::*;
#(
    parameter int POINTS_PER_PACKET = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [3:0] point_index, [35:4] point_word, [43:36] lead_byte,
    // [59:44] rotation_speed, [75:60] first_angle, [107:76] packet_check
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,   // last_point
    output int                   mismatch_count,
    output int                   points_pending
);

    // Bit offsets of the result fields in m_tdata
    localparam int WORD_LSB  = INDEX_W;
    localparam int LEAD_LSB  = WORD_LSB + WORD_W;
    localparam int SPEED_LSB = LEAD_LSB + LEAD_W;
    localparam int ANGLE_LSB = SPEED_LSB + SPEED_W;
    localparam int CHECK_LSB = ANGLE_LSB + ANGLE_W;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  word;
        logic [LEAD_W-1:0]  lead;
        logic [SPEED_W-1:0] speed;
        logic [ANGLE_W-1:0] angle;
        logic [CHECK_W-1:0] check;
        logic               last;
    } point_result_t;

    point_result_t expected_points[$];
    point_result_t oldest_point;

    // Shadow of the framing state
    ldf_state_t    phase;
    int            byte_count;
    logic [7:0]    held_lead;
    logic [7:0]    held_count;
    logic [15:0]   held_speed;
    logic [15:0]   held_angle;
    logic [31:0]   point_store [POINTS_PER_PACKET];
    logic [23:0]   check_partial;

    // Advance the framing state by one byte; queue the points on the last footer byte
    task automatic track_byte(input logic [7:0] rx_byte);
        int            word;
        int            lane;
        logic [31:0]   check_word;
        point_result_t res;
        case (phase)
            ST_HUNT2: begin
                if (rx_byte == SYNC_SECOND) begin
                    phase = ST_HEADER;
                    byte_count = 0;
                end else begin
                    phase = ST_HUNT1;
                end
            end
            ST_HEADER: begin
                case (byte_count)
                    HDR_LEAD:     held_lead = rx_byte;
                    HDR_COUNT:    held_count = rx_byte;
                    HDR_SPEED_LO: held_speed[7:0] = rx_byte;
                    HDR_SPEED_HI: held_speed[15:8] = rx_byte;
                    HDR_ANGLE_LO: held_angle[7:0] = rx_byte;
                    default:      held_angle[15:8] = rx_byte;
                endcase
                byte_count++;
                if (byte_count >= HEADER_BYTES) begin
                    byte_count = 0;
                    // drop the packet on a wrong point count
                    phase = (held_count == POINTS_PER_PACKET) ? ST_PAYLOAD : ST_HUNT1;
                end
            end
            ST_PAYLOAD: begin
                word = byte_count / WORD_BYTES;
                lane = byte_count % WORD_BYTES;
                if (lane == LANE_0) begin
                    point_store[word] = {24'h000000, rx_byte};
                end else begin
                    point_store[word][lane*8 +: 8] = rx_byte;
                end
                byte_count++;
                if (byte_count >= WORD_BYTES * POINTS_PER_PACKET) begin
                    byte_count = 0;
                    phase = ST_FOOTER;
                end
            end
            ST_FOOTER: begin
                if (byte_count < FOOTER_BYTES - 1) begin
                    check_partial[byte_count*8 +: 8] = rx_byte;
                    byte_count++;
                end else begin
                    check_word = {rx_byte, check_partial};
                    byte_count = 0;
                    phase = ST_HUNT1;
                    for (int i = 0; i < POINTS_PER_PACKET; i++) begin
                        res.index = i[INDEX_W-1:0];
                        res.word  = point_store[i];
                        res.lead  = held_lead;
                        res.speed = held_speed;
                        res.angle = held_angle;
                        res.check = check_word;
                        res.last  = (i == POINTS_PER_PACKET - 1);
                        expected_points.push_back(res);
                    end
                end
            end
            default: begin
                // unused codes act as hunting the first sync byte
                phase = (rx_byte == SYNC_FIRST) ? ST_HUNT2 : ST_HUNT1;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] expected_v,
                               input logic [31:0] actual_v);
        if (expected_v !== actual_v) begin
            $display("%0t: %s expected %h, actual %h", $time, name, expected_v, actual_v);
            mismatch_count++;
        end
    endtask

    // Track accepted bytes and compare accepted results in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            phase = ST_HUNT1;
            byte_count = 0;
            held_lead = '0;
            held_count = '0;
            held_speed = '0;
            held_angle = '0;
            check_partial = '0;
            for (int i = 0; i < POINTS_PER_PACKET; i++) point_store[i] = '0;
            expected_points.delete();
            mismatch_count = 0;
        end else begin
            if (s_tvalid && s_tready) track_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: result with no point pending, expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    oldest_point = expected_points.pop_front();
                    check_field("point_index", 32'(oldest_point.index),
                                32'(m_tdata[INDEX_W-1:0]));
                    check_field("point_word", oldest_point.word, m_tdata[WORD_LSB +: WORD_W]);
                    check_field("lead_byte", 32'(oldest_point.lead),
                                32'(m_tdata[LEAD_LSB +: LEAD_W]));
                    check_field("rotation_speed", 32'(oldest_point.speed),
                                32'(m_tdata[SPEED_LSB +: SPEED_W]));
                    check_field("first_angle", 32'(oldest_point.angle),
                                32'(m_tdata[ANGLE_LSB +: ANGLE_W]));
                    check_field("packet_check", oldest_point.check,
                                m_tdata[CHECK_LSB +: CHECK_W]);
                    check_field("tdata padding", 32'h0,
                                32'(m_tdata[M_TDATA_W-1:FIELDS_W]));
                    check_field("last_point", 32'(oldest_point.last), 32'(m_tlast));
                end
            end
        end
        points_pending <= expected_points.size();
    end

endmodule

FILE: test/testbench.sv
// Testbench top for the lidar packet deframer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import ldf_pkg::*;

    localparam int POINTS          = 12;
    localparam int MAX_WAIT        = 16;
    localparam int IDLE_LIMIT      = 2000;
    localparam int FRAME_TARGET    = 260;
    localparam int MIN_GOOD_FRAMES = 3;
    localparam int DRAIN_CYCLES    = 20;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    // [3:0] point_index, [35:4] point_word, [43:36] lead_byte,
    // [59:44] rotation_speed, [75:60] first_angle, [107:76] packet_check
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;   // last_point

    int mismatch_count;
    int points_pending;
    int idle_cycles = 0;
    int rx_wait = 0;
    bit rx_calm = 1'b0;
    bit sender_calm = 1'b0;
    int frame_bytes = 0;
    int good_frames = 0;

    always #5 aclk = ~aclk;

    lidar_packet_deframer #(
        .POINTS_PER_PACKET(POINTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    lidar_packet_deframer_checker #(
        .POINTS_PER_PACKET(POINTS)
    ) point_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_count),
        .points_pending(points_pending)
    );

    // Stall the result stream for a random count after each transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_wait = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (m_tlast) rx_calm = ($urandom_range(0, 2) == 0);
                rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    // Abort when no transaction moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] rx_byte);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx_byte;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Frame content biased toward the extremes and the first sync value
    function automatic logic [7:0] frame_byte(input fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default: begin
                case ($urandom_range(0, 7))
                    0:       return 8'h00;
                    1:       return 8'hFF;
                    2:       return SYNC_FIRST;
                    default: return 8'($urandom_range(0, 255));
                endcase
            end
        endcase
    endfunction

    // Send sync pair and header; follow with payload and footer on a matching count
    task automatic send_frame(input logic [7:0] count, input fill_t fill);
        sender_calm = ($urandom_range(0, 3) == 0);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(frame_byte(fill));
        send_byte(count);
        repeat (HEADER_BYTES - 2) send_byte(frame_byte(fill));
        frame_bytes += HEADER_BYTES + 2;
        if (count == POINTS) begin
            repeat (WORD_BYTES * POINTS + FOOTER_BYTES) send_byte(frame_byte(fill));
            frame_bytes += WORD_BYTES * POINTS + FOOTER_BYTES;
            good_frames++;
        end
    endtask

    initial begin
        int   pick;
        int   bad_count;
        fill_t fill;
        logic [7:0] noise;

        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Junk while hunting, a repeated first sync byte, a broken sync pair
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        // Drop headers with the lowest and highest wrong point count
        send_frame(8'h00, FILL_RANDOM);
        send_frame(8'hFF, FILL_RANDOM);

        // Mostly full packets, some noise and broken framing
        while (frame_bytes < FRAME_TARGET || good_frames < MIN_GOOD_FRAMES) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    sender_calm = 1'b0;
                    repeat ($urandom_range(1, 6)) begin
                        noise = 8'($urandom_range(0, 255));
                        if (noise == SYNC_FIRST) noise = 8'h5A;
                        send_byte(noise);
                    end
                end
                1: begin
                    noise = 8'($urandom_range(0, 255));
                    if (noise == SYNC_SECOND) noise = 8'h00;
                    send_byte(SYNC_FIRST);
                    send_byte(noise);
                end
                2: begin
                    if ($urandom_range(0, 1)) begin
                        bad_count = $urandom_range(0, 1) ? POINTS + 1 : POINTS - 1;
                    end else begin
                        bad_count = $urandom_range(0, 255);
                        if (bad_count == POINTS) bad_count = 0;
                    end
                    send_frame(8'(bad_count), FILL_RANDOM);
                end
                default: begin
                    if (good_frames == 0) fill = FILL_ONES;
                    else if (good_frames == 1) fill = FILL_ZERO;
                    else fill = FILL_RANDOM;
                    send_frame(8'(POINTS), fill);
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding points, then allow for late extras
        @(posedge aclk);
        while (points_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
